### rtl/core/cfib_pkg.sv
// Shared types and constants for the clipped, flipped image blit core.
package cfib_pkg;

  // Fixed field widths
  localparam int unsigned COLOR_W   = 24;
  localparam int unsigned ADDR_W    = 19;
  localparam int unsigned REG_W     = 13;
  localparam int unsigned OFFSET_W  = 12;
  localparam int unsigned CFG_IDX_W = 3;

  // Signed working width for screen and image coordinates (covers every
  // register value and image dimension in range)
  localparam int unsigned COORD_W   = 16;
  // Bits of a screen coordinate once it is known to lie on the screen
  localparam int unsigned SCR_W     = 12;
  localparam int unsigned PROD_W    = 2 * SCR_W + 1;

  // Default build values
  localparam int unsigned DEF_SCREEN_W      = 800;
  localparam int unsigned DEF_SCREEN_H      = 480;
  localparam int unsigned DEF_MAX_IMAGE_DIM = 4096;

  // Register reset values
  localparam logic [REG_W-1:0]    RST_IMAGE_WIDTH  = 13'd800;
  localparam logic [REG_W-1:0]    RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [REG_W-1:0]    RST_DEST_X       = 13'd0;
  localparam logic [REG_W-1:0]    RST_DEST_Y       = 13'd0;
  localparam logic [REG_W-1:0]    RST_WINDOW_W     = 13'd800;
  localparam logic [REG_W-1:0]    RST_WINDOW_H     = 13'd480;
  localparam logic [OFFSET_W-1:0] RST_FIRST_COL    = 12'd0;
  localparam logic [OFFSET_W-1:0] RST_FIRST_ROW    = 12'd0;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_DEST_X       = 3'd2,
    REG_DEST_Y       = 3'd3,
    REG_WINDOW_W     = 3'd4,
    REG_WINDOW_H     = 3'd5,
    REG_FIRST_COL    = 3'd6,
    REG_FIRST_ROW    = 3'd7
  } cfg_idx_t;

  // Configuration register set
  typedef struct packed {
    logic        [REG_W-1:0]    image_width;
    logic        [REG_W-1:0]    image_height;
    logic signed [REG_W-1:0]    dest_x;
    logic signed [REG_W-1:0]    dest_y;
    logic        [REG_W-1:0]    window_w;
    logic        [REG_W-1:0]    window_h;
    logic        [OFFSET_W-1:0] first_col;
    logic        [OFFSET_W-1:0] first_row;
  } cfg_t;

  // Input request payload
  typedef struct packed {
    logic [COLOR_W-1:0] pixel_color;
    logic               frame_start;
  } in_t;

  // Result request payload
  typedef struct packed {
    logic               write_enable;
    logic [ADDR_W-1:0]  screen_address;
    logic [COLOR_W-1:0] write_color;
    logic               image_done;
  } out_t;

endpackage

### rtl/core/cfib_clip.sv
// Per-pixel flip, window clip, screen clip and frame-buffer address unit.
module cfib_clip #(
  parameter int unsigned SCREEN_W = cfib_pkg::DEF_SCREEN_W,
  parameter int unsigned SCREEN_H = cfib_pkg::DEF_SCREEN_H,
  parameter int unsigned CNT_W    = 12,
  parameter int unsigned DIM_W    = 13
) (
  input  cfib_pkg::cfg_t                   cfg,
  input  logic [DIM_W-1:0]                 img_w,
  input  logic [DIM_W-1:0]                 img_h,
  input  logic [CNT_W-1:0]                 col,
  input  logic [CNT_W-1:0]                 row,
  input  logic [cfib_pkg::COLOR_W-1:0]     color,
  input  logic                             done,
  output cfib_pkg::out_t                   res
);

  localparam int unsigned CW = cfib_pkg::COORD_W;
  localparam int unsigned SW = cfib_pkg::SCR_W;
  localparam int unsigned PW = cfib_pkg::PROD_W;
  localparam int unsigned RW = cfib_pkg::REG_W;

  logic signed [CW-1:0] x_s, y_s, w_s, ox_s, oy_s, ww_s, wh_s, dx_s, dy_s;
  logic signed [CW-1:0] sx_s, sy_s;
  logic                 in_window, on_screen, keep;
  logic [PW-1:0]        row_base, addr_full;

  // Widen everything to the signed working width
  assign x_s  = signed'(CW'(col));
  assign w_s  = signed'(CW'(img_w));
  assign ox_s = signed'(CW'(cfg.first_col));
  assign oy_s = signed'(CW'(cfg.first_row));
  assign ww_s = signed'(CW'(cfg.window_w));
  assign wh_s = signed'(CW'(cfg.window_h));
  assign dx_s = signed'({{(CW-RW){cfg.dest_x[RW-1]}}, cfg.dest_x});
  assign dy_s = signed'({{(CW-RW){cfg.dest_y[RW-1]}}, cfg.dest_y});

  // Flip the stored row into a top-down display row
  assign y_s = signed'(CW'(img_h)) - signed'(CW'(1)) - signed'(CW'(row));

  // Clip against the offset window and the image
  assign in_window = (y_s >= oy_s) && (y_s < oy_s + wh_s) &&
                     (x_s >= ox_s) && (x_s < ox_s + ww_s) && (x_s < w_s);

  // Place on the screen and clip against its edges
  assign sx_s = dx_s + x_s - ox_s;
  assign sy_s = dy_s + y_s - oy_s;
  assign on_screen = (sx_s >= signed'(CW'(0))) && (sx_s < signed'(CW'(SCREEN_W))) &&
                     (sy_s >= signed'(CW'(0))) && (sy_s < signed'(CW'(SCREEN_H)));

  assign keep = in_window && on_screen;

  // Row-major frame-buffer word address
  assign row_base  = PW'(sy_s[SW-1:0]) * PW'(SCREEN_W);
  assign addr_full = row_base + PW'(sx_s[SW-1:0]);

  assign res.write_enable   = keep;
  assign res.screen_address = keep ? addr_full[cfib_pkg::ADDR_W-1:0] : '0;
  assign res.write_color    = color;
  assign res.image_done     = done;

endmodule

### rtl/core/clipped_flipped_image_blit_core.sv
// Top level of the clipped, vertically flipped image blit core.
// Takes one source pixel per clock, bottom stored row first, and returns
// exactly one result per pixel: a frame-buffer write (address and colour) or
// a dropped pixel, plus an end-of-image flag. Throughput is one pixel per
// cycle whenever the result side does not stall. Each pixel passes through
// the position register after the row/column counters and then the result
// register after the clip and multiply-add unit. Width and height are
// clamped to 1..MAX_IMAGE_DIM; a request with frame_start restarts the
// counters at that pixel. Write configuration only while no pixel is in
// flight.
module clipped_flipped_image_blit_core #(
  parameter int unsigned SCREEN_W      = cfib_pkg::DEF_SCREEN_W,
  parameter int unsigned SCREEN_H      = cfib_pkg::DEF_SCREEN_H,
  parameter int unsigned MAX_IMAGE_DIM = cfib_pkg::DEF_MAX_IMAGE_DIM
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [cfib_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cfib_pkg::REG_W-1:0]         cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  cfib_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output cfib_pkg::out_t                     out_data
);

  localparam int unsigned CNT_W = $clog2(MAX_IMAGE_DIM);
  localparam int unsigned DIM_W = $clog2(MAX_IMAGE_DIM + 1);

  cfib_pkg::cfg_t cfg_r;

  logic [DIM_W-1:0]  img_w, img_h;
  logic [CNT_W-1:0]  col_r, col_nxt, row_r, row_nxt;
  logic [CNT_W-1:0]  x_cur, row_cur;
  logic              row_end, img_end, in_acc, out_load;

  logic                          s1_v_r, s1_v_nxt;
  logic [CNT_W-1:0]              s1_col_r, s1_row_r;
  logic                          s1_done_r;
  logic [cfib_pkg::COLOR_W-1:0]  s1_color_r;

  logic              out_valid_r, out_valid_nxt;
  cfib_pkg::out_t    out_data_r, res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= cfib_pkg::RST_IMAGE_WIDTH;
      cfg_r.image_height <= cfib_pkg::RST_IMAGE_HEIGHT;
      cfg_r.dest_x       <= signed'(cfib_pkg::RST_DEST_X);
      cfg_r.dest_y       <= signed'(cfib_pkg::RST_DEST_Y);
      cfg_r.window_w     <= cfib_pkg::RST_WINDOW_W;
      cfg_r.window_h     <= cfib_pkg::RST_WINDOW_H;
      cfg_r.first_col    <= cfib_pkg::RST_FIRST_COL;
      cfg_r.first_row    <= cfib_pkg::RST_FIRST_ROW;
    end else if (cfg_we) begin
      unique case (cfib_pkg::cfg_idx_t'(cfg_index))
        cfib_pkg::REG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_wdata;
        cfib_pkg::REG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_wdata;
        cfib_pkg::REG_DEST_X:       cfg_r.dest_x       <= signed'(cfg_wdata);
        cfib_pkg::REG_DEST_Y:       cfg_r.dest_y       <= signed'(cfg_wdata);
        cfib_pkg::REG_WINDOW_W:     cfg_r.window_w     <= cfg_wdata;
        cfib_pkg::REG_WINDOW_H:     cfg_r.window_h     <= cfg_wdata;
        cfib_pkg::REG_FIRST_COL:    cfg_r.first_col    <= cfg_wdata[cfib_pkg::OFFSET_W-1:0];
        cfib_pkg::REG_FIRST_ROW:    cfg_r.first_row    <= cfg_wdata[cfib_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp image dimensions to 1..MAX_IMAGE_DIM
  always_comb begin
    if (cfg_r.image_width == '0) begin
      img_w = DIM_W'(1);
    end else if (32'(cfg_r.image_width) > MAX_IMAGE_DIM) begin
      img_w = DIM_W'(MAX_IMAGE_DIM);
    end else begin
      img_w = DIM_W'(cfg_r.image_width);
    end
    if (cfg_r.image_height == '0) begin
      img_h = DIM_W'(1);
    end else if (32'(cfg_r.image_height) > MAX_IMAGE_DIM) begin
      img_h = DIM_W'(MAX_IMAGE_DIM);
    end else begin
      img_h = DIM_W'(cfg_r.image_height);
    end
  end

  // Handshake: the result register loads when empty or being drained
  assign out_load = !out_valid_r || !out_stall;
  assign in_stall = s1_v_r && !out_load;
  assign in_acc   = in_valid && !in_stall;

  // Position of this pixel and counter advance
  always_comb begin
    x_cur   = in_data.frame_start ? '0 : col_r;
    row_cur = in_data.frame_start ? '0 : row_r;
    row_end = (32'(x_cur) + 32'd1) >= 32'(img_w);
    img_end = row_end && ((32'(row_cur) + 32'd1) >= 32'(img_h));
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = img_end ? '0 : row_cur + CNT_W'(1);
      end else begin
        col_nxt = x_cur + CNT_W'(1);
        row_nxt = row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Position register: hold while the result side is full and stalled
  assign s1_v_nxt = in_acc ? 1'b1 : (out_load ? 1'b0 : s1_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col_r   <= x_cur;
      s1_row_r   <= row_cur;
      s1_done_r  <= img_end;
      s1_color_r <= in_data.pixel_color;
    end
  end

  // Flip, clip and address the registered pixel
  cfib_clip #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H),
    .CNT_W    (CNT_W),
    .DIM_W    (DIM_W)
  ) u_clip (
    .cfg   (cfg_r),
    .img_w (img_w),
    .img_h (img_h),
    .col   (s1_col_r),
    .row   (s1_row_r),
    .color (s1_color_r),
    .done  (s1_done_r),
    .res   (res)
  );

  // Result register
  assign out_valid_nxt = out_load ? s1_v_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_v_r) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/core/cfib_checker.sv
// Port-level checks for the blit core, bound to its top level.
module cfib_checker #(
  parameter int unsigned SCREEN_W = cfib_pkg::DEF_SCREEN_W,
  parameter int unsigned SCREEN_H = cfib_pkg::DEF_SCREEN_H
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_stall,
  input  logic            out_valid,
  input  logic            out_stall,
  input  cfib_pkg::out_t  out_data
);

  localparam longint unsigned FB_WORDS = longint'(SCREEN_W) * longint'(SCREEN_H);
  localparam bit ADDR_WRAPS = FB_WORDS > (64'd1 << cfib_pkg::ADDR_W);

  // A stalled result request holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result request changed while stalled");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // An empty result register never stalls the input
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

  // Dropped pixels carry a zero address
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.write_enable |-> out_data.screen_address == '0)
    else $error("dropped pixel with non-zero address");

  // Writes land inside the frame buffer, when it fits the address width
  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.write_enable |->
      ADDR_WRAPS || (64'(out_data.screen_address) < FB_WORDS))
    else $error("write address beyond frame buffer");

endmodule

bind clipped_flipped_image_blit_core cfib_checker #(
  .SCREEN_W (SCREEN_W),
  .SCREEN_H (SCREEN_H)
) u_cfib_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
